// ===== hdl/dlm_pkg.sv =====
`default_nettype none

package dlm_pkg;

    localparam int MAX_IN  = 256;
    localparam int MAX_OUT = 16;

    // weight memory address, neuron index and neuron count widths
    localparam int AW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int NW = $clog2(MAX_OUT + 1);

    localparam int ACC_W = 41;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    localparam logic REG_IN_COUNT  = 1'b0;
    localparam logic REG_OUT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_WEIGHT,
        KIND_BIAS,
        KIND_FEATURE
    } kind_t;

    // one item as it travels down the row of cells
    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [3:0]          oi;
        logic [7:0]          ii;
        logic signed [31:0]  value;
        logic signed [15:0]  val16;
        logic                first;
        logic                final_item;
        logic [NW-1:0]       n_out;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } res_t;

    typedef struct packed {
        logic capture;
        logic shift;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dense_layer_mac_core.sv =====
`default_nettype none

// channel   dir  tvalid/tready  tdata (low bit up)                         tuser / tlast
// s_*       in   s_tvalid/rdy   out_index[3:0] in_index[11:4] value[43:12]  s_tuser: command
// m_*       out  m_tvalid/rdy   out_index_res[3:0] result_value[35:4]        m_tuser: saturated,
//                                                                             m_tlast: last
// cfg_*     in   cfg_we         cfg_index 0 in_count, 1 out_count; cfg_data
//
// one input transaction per cycle while s_tready is high; each item walks the row of MAX_OUT
// cells one cell at a time; after the final feature of a vector the input is held off; results
// are captured once that item has left the last cell, in the capture state, and then leave one
// per cycle while m_tready is high through the cell result shift chain, neuron 0 first; input
// reopens the cycle after the last result; reset clears control state and accumulators, not
// weight and bias stores; m_tready low holds the current result and the whole shift chain

module dense_layer_mac_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // out_index, in_index, value, zero pad
    input  wire  [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_index_res, result_value, zero pad
    output logic [0:0]  m_tuser,   // saturated
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [8:0]  cfg_data
);
    import dlm_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_CAPTURE,
        ST_DRAIN
    } state_t;

    state_t         state_reg;
    logic [8:0]     in_count_reg;
    logic [4:0]     out_count_reg;
    logic [8:0]     n_in;
    logic [NW-1:0]  n_out;
    logic [NW-1:0]  n_out_cap_reg;
    logic [OW-1:0]  idx_reg;
    logic           s_fire;
    logic           m_fire;
    logic           is_last;
    logic           in_range;
    logic [3:0]     s_oi;
    logic [7:0]     s_ii;
    logic signed [31:0] s_value;
    logic signed [15:0] s_val16;
    item_t          item_reg;
    item_t          chain [MAX_OUT+1];
    res_t           res_chain [MAX_OUT+1];
    ctl_t           ctl;
    logic           tail_final;

    assign s_oi    = s_tdata[3:0];
    assign s_ii    = s_tdata[11:4];
    assign s_value = s_tdata[43:12];

    assign n_in  = (in_count_reg == 9'd0) ? 9'd1
                 : ((32'(in_count_reg) > MAX_IN) ? 9'(MAX_IN) : in_count_reg);
    assign n_out = (out_count_reg == 5'd0) ? NW'(1)
                 : ((32'(out_count_reg) > MAX_OUT) ? NW'(MAX_OUT) : NW'(out_count_reg));

    assign s_val16 = (s_value > 32'sd32767) ? 16'sh7FFF
                   : ((s_value < -32'sd32768) ? 16'sh8000 : s_value[15:0]);

    assign in_range = {1'b0, s_ii} < n_in;
    assign s_tready = (state_reg == ST_RUN);
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign is_last  = (NW'(idx_reg) == n_out_cap_reg - NW'(1));

    assign ctl.capture = (state_reg == ST_CAPTURE);
    assign ctl.shift   = m_fire;

    assign tail_final = chain[MAX_OUT].valid && chain[MAX_OUT].kind == KIND_FEATURE
                      && chain[MAX_OUT].final_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg      <= '0;
            in_count_reg  <= 9'd256;
            out_count_reg <= 5'd16;
        end
        else
        begin
            item_reg.valid <= s_fire;
            case (s_tuser)
                CMD_WEIGHT:  item_reg.kind <= KIND_WEIGHT;
                CMD_BIAS:    item_reg.kind <= KIND_BIAS;
                CMD_FEATURE: item_reg.kind <= in_range ? KIND_FEATURE : KIND_IDLE;
                default:     item_reg.kind <= KIND_IDLE;
            endcase
            item_reg.oi         <= s_oi;
            item_reg.ii         <= s_ii;
            item_reg.value      <= s_value;
            item_reg.val16      <= s_val16;
            item_reg.first      <= (s_ii == 8'd0);
            item_reg.final_item <= ({1'b0, s_ii} == n_in - 9'd1);
            item_reg.n_out      <= n_out;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IN_COUNT:  in_count_reg  <= cfg_data;
                    REG_OUT_COUNT: out_count_reg <= cfg_data[4:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            idx_reg       <= '0;
            n_out_cap_reg <= NW'(1);
        end
        else
        begin
            case (state_reg)
                ST_RUN:
                begin
                    if (s_fire && s_tuser == CMD_FEATURE && in_range
                        && {1'b0, s_ii} == n_in - 9'd1)
                    begin
                        state_reg     <= ST_FLUSH;
                        n_out_cap_reg <= n_out;
                    end
                end
                ST_FLUSH:
                begin
                    // last cell updates its accumulator at this edge
                    if (tail_final)
                    begin
                        state_reg <= ST_CAPTURE;
                    end
                end
                ST_CAPTURE:
                begin
                    state_reg <= ST_DRAIN;
                    idx_reg   <= '0;
                end
                ST_DRAIN:
                begin
                    if (m_fire)
                    begin
                        idx_reg <= idx_reg + OW'(1);
                        if (is_last)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign chain[0]           = item_reg;
    assign res_chain[MAX_OUT] = '0;

    for (genvar j = 0; j < MAX_OUT; j++)
    begin : g_cell
        dlm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (OW'(j)),
            .item_in  (chain[j]),
            .item_out (chain[j+1]),
            .ctl      (ctl),
            .res_in   (res_chain[j+1]),
            .res_out  (res_chain[j])
        );
    end

    assign m_tdata = {4'd0, res_chain[0].value, 4'(idx_reg)};
    assign m_tuser = res_chain[0].sat;
    assign m_tlast = is_last;

endmodule

`default_nettype wire

// ===== hdl/dlm_cell.sv =====
`default_nettype none

module dlm_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire [dlm_pkg::OW-1:0] cell_id,
    input  dlm_pkg::item_t        item_in,
    output dlm_pkg::item_t        item_out,
    input  dlm_pkg::ctl_t         ctl,
    input  dlm_pkg::res_t         res_in,
    output dlm_pkg::res_t         res_out
);
    import dlm_pkg::*;

    logic [15:0]              wmem [MAX_IN];
    logic signed [15:0]       rd_reg;
    logic signed [31:0]       bias_reg;
    item_t                    p_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [31:0]       prod;
    logic                     mine;
    logic                     in_use;
    res_t                     res_reg;
    res_t                     res_next;
    logic                     over;

    assign mine   = (32'(item_in.oi) < MAX_OUT) && (OW'(item_in.oi) == cell_id);
    assign in_use = NW'(cell_id) < p_reg.n_out;
    assign prod   = p_reg.val16 * rd_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (p_reg.valid && p_reg.kind == KIND_FEATURE && in_use)
        begin
            acc_next = (p_reg.first ? ACC_W'(bias_reg) : acc_reg) + ACC_W'(prod);
        end
    end

    // acc fits in 32 bits only when bits 40..31 agree
    assign over = !((&acc_reg[ACC_W-1:31]) || !(|acc_reg[ACC_W-1:31]));

    always_comb
    begin
        res_next = res_reg;
        if (ctl.capture)
        begin
            res_next.sat   = over;
            res_next.value = !over ? acc_reg[31:0]
                           : (acc_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        else if (ctl.shift)
        begin
            res_next = res_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid)
        begin
            rd_reg <= wmem[AW'(item_in.ii)];
            if (item_in.kind == KIND_WEIGHT && mine && 32'(item_in.ii) < MAX_IN)
            begin
                wmem[AW'(item_in.ii)] <= item_in.val16;
            end
            if (item_in.kind == KIND_BIAS && mine)
            begin
                bias_reg <= item_in.value;
            end
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            p_reg   <= item_in;
            acc_reg <= acc_next;
        end
    end

    assign item_out = p_reg;
    assign res_out  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/dlm_checker.sv =====
`default_nettype none

module dlm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no input is taken while results drain
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during result drain");

    // results of one vector leave back to back until the last one
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result burst broken before last");

    // input reopens right after the last result
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not reopened after last result");

    // each burst starts at neuron zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> m_tdata[3:0] == 4'd0)
        else $error("result burst does not start at neuron zero");

endmodule

bind dense_layer_mac_core dlm_checker u_dlm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
